/* rtl/csvft_pkg.sv */
`timescale 1ns / 1ps

package csvft_pkg;

	localparam int MAX_COLS_DEF = 32;

	localparam int BYTE_W = 8;
	localparam int ROW_W  = 16;
	localparam int COL_W  = 8;

	localparam logic [BYTE_W-1:0] QUOTE_BYTE   = 8'h22;
	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

	localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd59;
	localparam logic              PAD_RESET   = 1'b0;

	localparam logic CFG_DELIMITER  = 1'b0;
	localparam logic CFG_PAD_ENABLE = 1'b1;

	typedef enum logic [2:0] {
		KIND_BYTE     = 3'd0,
		KIND_FIELD    = 3'd1,
		KIND_PAD      = 3'd2,
		KIND_COL_ERR  = 3'd3,
		KIND_HDR_WIDE = 3'd4,
		KIND_DONE     = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ERR,
		ST_HDRW,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_BYTE,
		OP_PAD,
		OP_ERR,
		OP_HDRW,
		OP_DONE
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		op_t  op;
		logic last;
		logic row_end;
		logic halt;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic halted;
		logic is_eoi;
		logic row_end;
		logic cc_zero;
		logic hdr_known;
		logic next_lt_hdr;
		logic next_gt_max;
		logic pad_en;
		logic pad_last;
	} sts_t;

endpackage

/* rtl/csv_field_tokenizer.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// cfg      in         cfg_we               cfg_index, cfg_data
// in       in         in_valid / in_stall  text_byte, end_of_input
// out      out        out_valid/out_stall  kind, data_byte, row, column, last
//
// An ordinary byte is registered into the output register; a new request is taken every
// cycle while the output register drains and the controller is idle.
// A row end or end of text may add extra results (padded field ends, column error,
// header flag, done), issued one at a time through the single output register.
// Reset clears the quote, row, column and header state and restores the config registers.
// A stalled output holds its result and stalls the input side in turn.

module csv_field_tokenizer #(
	parameter int MAX_COLS = csvft_pkg::MAX_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [csvft_pkg::BYTE_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [csvft_pkg::BYTE_W-1:0]  text_byte,
	input  logic                          end_of_input,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    kind,
	output logic [csvft_pkg::BYTE_W-1:0]  data_byte,
	output logic [csvft_pkg::ROW_W-1:0]   row,
	output logic [csvft_pkg::COL_W-1:0]   column,
	output logic                          last
);

	csvft_pkg::cmd_t cmd;
	csvft_pkg::sts_t sts;

	csvft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	csvft_dp #(
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.row          (row),
		.column       (column),
		.last         (last),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

/* rtl/csvft_ctrl.sv */
`timescale 1ns / 1ps

module csvft_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  csvft_pkg::sts_t   sts,
	output csvft_pkg::cmd_t   cmd
);

	csvft_pkg::state_t state_q;
	csvft_pkg::state_t state_d;
	csvft_pkg::state_t tgt;
	logic              eoi_seq_q;
	logic              accept;
	logic              live;

	assign accept   = in_valid && (state_q == csvft_pkg::ST_IDLE) && sts.out_free;
	assign live     = accept && !sts.halted;
	assign in_stall = !((state_q == csvft_pkg::ST_IDLE) && sts.out_free);

	// Where a row close goes after its field end has been loaded.
	always_comb begin
		if (sts.is_eoi) begin
			if (sts.hdr_known && sts.next_lt_hdr)
				tgt = sts.pad_en ? csvft_pkg::ST_PAD : csvft_pkg::ST_ERR;
			else
				tgt = csvft_pkg::ST_DONE;
		end else if (!sts.hdr_known) begin
			tgt = sts.next_gt_max ? csvft_pkg::ST_HDRW : csvft_pkg::ST_IDLE;
		end else if (sts.next_lt_hdr) begin
			tgt = sts.pad_en ? csvft_pkg::ST_PAD : csvft_pkg::ST_ERR;
		end else begin
			tgt = csvft_pkg::ST_IDLE;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			csvft_pkg::ST_IDLE: begin
				if (live && (sts.is_eoi ? !sts.cc_zero : sts.row_end))
					state_d = tgt;
			end
			csvft_pkg::ST_PAD: begin
				if (sts.out_free && sts.pad_last)
					state_d = eoi_seq_q ? csvft_pkg::ST_DONE : csvft_pkg::ST_IDLE;
			end
			csvft_pkg::ST_ERR, csvft_pkg::ST_HDRW, csvft_pkg::ST_DONE: begin
				if (sts.out_free)
					state_d = csvft_pkg::ST_IDLE;
			end
			default: state_d = csvft_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op      = csvft_pkg::OP_NONE;
		cmd.last    = 1'b0;
		cmd.row_end = 1'b0;
		cmd.halt    = 1'b0;
		case (state_q)
			csvft_pkg::ST_IDLE: begin
				if (live) begin
					if (sts.is_eoi && sts.cc_zero) begin
						cmd.op   = csvft_pkg::OP_DONE;
						cmd.last = 1'b1;
						cmd.halt = 1'b1;
					end else begin
						cmd.op = csvft_pkg::OP_BYTE;
						if (sts.is_eoi) begin
							cmd.last = 1'b0;
						end else if (sts.row_end) begin
							cmd.last    = (tgt == csvft_pkg::ST_IDLE);
							cmd.row_end = (tgt == csvft_pkg::ST_IDLE);
						end else begin
							cmd.last = 1'b1;
						end
					end
				end
			end
			csvft_pkg::ST_PAD: begin
				if (sts.out_free) begin
					cmd.op = csvft_pkg::OP_PAD;
					if (sts.pad_last && !eoi_seq_q) begin
						cmd.last    = 1'b1;
						cmd.row_end = 1'b1;
					end
				end
			end
			csvft_pkg::ST_ERR: begin
				if (sts.out_free) begin
					cmd.op   = csvft_pkg::OP_ERR;
					cmd.last = 1'b1;
					cmd.halt = 1'b1;
				end
			end
			csvft_pkg::ST_HDRW: begin
				if (sts.out_free) begin
					cmd.op      = csvft_pkg::OP_HDRW;
					cmd.last    = 1'b1;
					cmd.row_end = 1'b1;
				end
			end
			csvft_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.op   = csvft_pkg::OP_DONE;
					cmd.last = 1'b1;
					cmd.halt = 1'b1;
				end
			end
			default: cmd.op = csvft_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= csvft_pkg::ST_IDLE;
			eoi_seq_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (live)
				eoi_seq_q <= sts.is_eoi;
		end
	end

endmodule

/* rtl/csvft_dp.sv */
`timescale 1ns / 1ps

module csvft_dp #(
	parameter int MAX_COLS = csvft_pkg::MAX_COLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [csvft_pkg::BYTE_W-1:0]   cfg_data,
	input  logic [csvft_pkg::BYTE_W-1:0]   text_byte,
	input  logic                           end_of_input,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     kind,
	output logic [csvft_pkg::BYTE_W-1:0]   data_byte,
	output logic [csvft_pkg::ROW_W-1:0]    row,
	output logic [csvft_pkg::COL_W-1:0]    column,
	output logic                           last,
	input  csvft_pkg::cmd_t                cmd,
	output csvft_pkg::sts_t                sts
);

	localparam int HDR_W = $clog2(MAX_COLS + 1);
	localparam logic [csvft_pkg::COL_W-1:0] MAX_COL_V = csvft_pkg::COL_W'(MAX_COLS);
	localparam logic [csvft_pkg::COL_W-1:0] COL_SAT   = {csvft_pkg::COL_W{1'b1}};
	localparam logic [csvft_pkg::ROW_W-1:0] ROW_SAT   = {csvft_pkg::ROW_W{1'b1}};

	logic [csvft_pkg::BYTE_W-1:0] delim_q;
	logic                         pad_en_q;
	logic                         in_quotes_q;
	logic                         quote_pend_q;
	logic [HDR_W-1:0]             hdr_q;
	logic [csvft_pkg::ROW_W-1:0]  row_q;
	logic [csvft_pkg::COL_W-1:0]  col_q;
	logic                         halted_q;

	logic                         out_valid_q;
	csvft_pkg::kind_t             kind_q;
	logic [csvft_pkg::BYTE_W-1:0] data_q;
	logic [csvft_pkg::ROW_W-1:0]  row_out_q;
	logic [csvft_pkg::COL_W-1:0]  col_out_q;
	logic                         last_q;

	logic                         is_quote;
	logic                         dropped;
	logic                         iq_eff;
	logic                         literal;
	logic                         is_delim;
	logic                         is_nl;
	logic [csvft_pkg::COL_W-1:0]  cc_next;
	logic [csvft_pkg::COL_W-1:0]  hdr_ext;
	logic                         out_free;

	assign out_free = !out_valid_q || !out_stall;

	// A quote that follows a pending quote is literal; any other byte after it
	// flips the quoting state before it is classified.
	assign is_quote = (text_byte == csvft_pkg::QUOTE_BYTE);
	assign dropped  = !quote_pend_q && is_quote;
	assign iq_eff   = (quote_pend_q && !is_quote) ? !in_quotes_q : in_quotes_q;
	assign literal  = is_quote || iq_eff;
	assign is_delim = !literal && (text_byte == delim_q);
	assign is_nl    = !literal && !is_delim && (text_byte == csvft_pkg::NEWLINE_BYTE);
	assign cc_next  = (col_q == COL_SAT) ? COL_SAT : col_q + 1'b1;
	assign hdr_ext  = csvft_pkg::COL_W'(hdr_q);

	assign sts.out_free    = out_free;
	assign sts.halted      = halted_q;
	assign sts.is_eoi      = end_of_input;
	assign sts.row_end     = is_nl;
	assign sts.cc_zero     = (col_q == '0);
	assign sts.hdr_known   = (hdr_q != '0);
	assign sts.next_lt_hdr = (cc_next < hdr_ext);
	assign sts.next_gt_max = (cc_next > MAX_COL_V);
	assign sts.pad_en      = pad_en_q;
	assign sts.pad_last    = ((col_q + 1'b1) == hdr_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q      <= csvft_pkg::DELIM_RESET;
			pad_en_q     <= csvft_pkg::PAD_RESET;
			in_quotes_q  <= 1'b0;
			quote_pend_q <= 1'b0;
			hdr_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			halted_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					csvft_pkg::CFG_DELIMITER:  delim_q  <= cfg_data;
					csvft_pkg::CFG_PAD_ENABLE: pad_en_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (cmd.op)
				csvft_pkg::OP_BYTE: begin
					if (end_of_input) begin
						out_valid_q <= 1'b1;
						col_q       <= cc_next;
					end else if (dropped) begin
						quote_pend_q <= 1'b1;
					end else begin
						quote_pend_q <= 1'b0;
						in_quotes_q  <= iq_eff;
						out_valid_q  <= 1'b1;
						if (is_delim || is_nl)
							col_q <= cc_next;
						if (is_nl && (hdr_q == '0))
							hdr_q <= (cc_next > MAX_COL_V) ? HDR_W'(MAX_COLS)
							                               : cc_next[HDR_W-1:0];
					end
				end
				csvft_pkg::OP_PAD: begin
					out_valid_q <= 1'b1;
					col_q       <= col_q + 1'b1;
				end
				csvft_pkg::OP_ERR, csvft_pkg::OP_HDRW, csvft_pkg::OP_DONE: begin
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase

			if (cmd.row_end) begin
				row_q <= (row_q == ROW_SAT) ? ROW_SAT : row_q + 1'b1;
				col_q <= '0;
			end
			if (cmd.halt)
				halted_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op != csvft_pkg::OP_NONE) begin
			row_out_q <= row_q;
			last_q    <= cmd.last;
			data_q    <= '0;
			col_out_q <= col_q;
			case (cmd.op)
				csvft_pkg::OP_BYTE: begin
					if (end_of_input || is_delim || is_nl) begin
						kind_q <= csvft_pkg::KIND_FIELD;
					end else begin
						kind_q <= csvft_pkg::KIND_BYTE;
						data_q <= text_byte;
					end
				end
				csvft_pkg::OP_PAD:  kind_q <= csvft_pkg::KIND_PAD;
				csvft_pkg::OP_ERR:  kind_q <= csvft_pkg::KIND_COL_ERR;
				csvft_pkg::OP_HDRW: begin
					kind_q    <= csvft_pkg::KIND_HDR_WIDE;
					col_out_q <= col_q - 1'b1;
				end
				csvft_pkg::OP_DONE: kind_q <= csvft_pkg::KIND_DONE;
				default:            kind_q <= csvft_pkg::KIND_BYTE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data_byte = data_q;
	assign row       = row_out_q;
	assign column    = col_out_q;
	assign last      = last_q;

endmodule

/* rtl/csvft_checker.sv */
`timescale 1ns / 1ps

module csvft_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    kind,
	input logic [csvft_pkg::BYTE_W-1:0]  data_byte,
	input logic [csvft_pkg::ROW_W-1:0]   row,
	input logic [csvft_pkg::COL_W-1:0]   column,
	input logic                          last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
			&& $stable(row) && $stable(column) && $stable(last))
		else $error("stalled result changed");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != csvft_pkg::KIND_BYTE) |-> (data_byte == '0))
		else $error("data byte set on a non-byte result");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((kind == csvft_pkg::KIND_DONE) || (kind == csvft_pkg::KIND_COL_ERR)
			|| (kind == csvft_pkg::KIND_HDR_WIDE)) |-> last)
		else $error("terminal result not marked last");

	// A stalled output register must also hold the input side back.
	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("request taken while the output register is blocked");

endmodule

bind csv_field_tokenizer csvft_checker u_csvft_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.data_byte (data_byte),
	.row       (row),
	.column    (column),
	.last      (last)
);
